// ===== rtl/pid_line_follower_drive_assert.svh =====
// Assertion macros for the line follower drive block.
// Each macro takes a label, a clock, an active-low reset, a condition and a consequence.
`ifndef PID_LINE_FOLLOWER_DRIVE_ASSERT_SVH
`define PID_LINE_FOLLOWER_DRIVE_ASSERT_SVH
`ifndef SYNTHESIS
`define PLFD_ASSERT_SAME(label, clk, rst_n, cond, cons) \
	label: assert property (@(posedge clk) disable iff (!rst_n) (cond) |-> (cons)) \
		else $error("same-cycle check failed");
`define PLFD_ASSERT_NEXT(label, clk, rst_n, cond, cons) \
	label: assert property (@(posedge clk) disable iff (!rst_n) (cond) |=> (cons)) \
		else $error("next-cycle check failed");
`else
`define PLFD_ASSERT_SAME(label, clk, rst_n, cond, cons)
`define PLFD_ASSERT_NEXT(label, clk, rst_n, cond, cons)
`endif
`endif

// ===== rtl/plfd_pkg.sv =====
package plfd_pkg;

	localparam int SENSOR_BITS   = 10;
	localparam int FRAC_BITS_DEF = 8;
	localparam int NUM_SENSORS   = 6;
	localparam int THRESH_W      = 10;
	localparam int GAIN_W        = 12;
	localparam int SPEED_W       = 8;
	localparam int SUM_W         = 24;
	localparam int COUNT_W       = 3;
	localparam int WSUM_W        = 5;
	localparam int DIV_STEPS     = 4;
	localparam int ACC_W         = 38;
	localparam int CMP_W         = (SENSOR_BITS > THRESH_W) ? SENSOR_BITS : THRESH_W;

	localparam int APB_DATA_W = 32;
	localparam int PADDR_W    = 5;
	localparam int REG_IDX_W  = 3;

	localparam logic [REG_IDX_W-1:0] REG_SENSE_THRESHOLD = 3'd0;
	localparam logic [REG_IDX_W-1:0] REG_GAIN_P          = 3'd1;
	localparam logic [REG_IDX_W-1:0] REG_GAIN_D          = 3'd2;
	localparam logic [REG_IDX_W-1:0] REG_GAIN_I          = 3'd3;
	localparam logic [REG_IDX_W-1:0] REG_CRUISE_SPEED    = 3'd4;
	localparam logic [REG_IDX_W-1:0] REG_SPEED_LIMIT     = 3'd5;
	localparam logic [REG_IDX_W-1:0] REG_SPIN_SPEED      = 3'd6;

	localparam logic [THRESH_W-1:0] RST_SENSE_THRESHOLD = 10'd512;
	localparam logic [GAIN_W-1:0]   RST_GAIN_P          = 12'd50;
	localparam logic [GAIN_W-1:0]   RST_GAIN_D          = 12'd1200;
	localparam logic [GAIN_W-1:0]   RST_GAIN_I          = 12'd5;
	localparam logic [SPEED_W-1:0]  RST_CRUISE_SPEED    = 8'd200;
	localparam logic [SPEED_W-1:0]  RST_SPEED_LIMIT     = 8'd255;
	localparam logic [SPEED_W-1:0]  RST_SPIN_SPEED      = 8'd180;

	typedef enum logic [1:0] {
		OP_FOLLOW = 2'd0,
		OP_CLEAR  = 2'd1,
		OP_STOP   = 2'd2
	} plfd_op_t;

	typedef enum logic [1:0] {
		MODE_FOLLOW = 2'd0,
		MODE_RIGHT  = 2'd1,
		MODE_LEFT   = 2'd2,
		MODE_UTURN  = 2'd3
	} plfd_mode_t;

	typedef enum logic [1:0] {
		TURN_NONE  = 2'd0,
		TURN_RIGHT = 2'd1,
		TURN_LEFT  = 2'd2
	} plfd_turn_t;

	typedef enum logic [3:0] {
		ST_IDLE,
		ST_EVAL,
		ST_DIV,
		ST_ERR,
		ST_MUL_P,
		ST_MUL_D,
		ST_MUL_I,
		ST_ACC,
		ST_SCALE,
		ST_EMIT
	} plfd_state_t;

	typedef struct packed {
		logic [1:0]             op;
		logic [SENSOR_BITS-1:0] reading_0;
		logic [SENSOR_BITS-1:0] reading_1;
		logic [SENSOR_BITS-1:0] reading_2;
		logic [SENSOR_BITS-1:0] reading_3;
		logic [SENSOR_BITS-1:0] reading_4;
		logic [SENSOR_BITS-1:0] reading_5;
	} plfd_sample_t;

	typedef struct packed {
		logic [SPEED_W-1:0] left_drive;
		logic [SPEED_W-1:0] right_drive;
		logic               left_backward;
		logic               right_backward;
		logic [1:0]         drive_mode;
		logic               all_seen;
		logic               line_lost;
	} plfd_drive_t;

	typedef struct packed {
		logic [THRESH_W-1:0] sense_threshold;
		logic [GAIN_W-1:0]   gain_p;
		logic [GAIN_W-1:0]   gain_d;
		logic [GAIN_W-1:0]   gain_i;
		logic [SPEED_W-1:0]  cruise_speed;
		logic [SPEED_W-1:0]  speed_limit;
		logic [SPEED_W-1:0]  spin_speed;
	} plfd_cfg_t;

	typedef struct packed {
		logic load;
		logic div_init;
		logic div_step;
		logic err_load;
		logic mul_p;
		logic mul_d;
		logic mul_i;
		logic acc_en;
		logic scale;
		logic commit;
	} plfd_cmd_t;

	typedef struct packed {
		logic pid_path;
	} plfd_stat_t;

endpackage

// ===== rtl/plfd_regs.sv =====
module plfd_regs import plfd_pkg::*; (
	input  logic                  clk,
	input  logic                  arst_n,
	input  logic                  psel,
	input  logic                  penable,
	input  logic                  pwrite,
	input  logic [PADDR_W-1:0]    paddr,
	input  logic [APB_DATA_W-1:0] pwdata,
	output logic [APB_DATA_W-1:0] prdata,
	output logic                  pready,
	output plfd_cfg_t             cfg
);

	plfd_cfg_t             cfg_q;
	logic [REG_IDX_W-1:0]  idx;
	logic                  wr_en;

	assign idx    = paddr[PADDR_W-1:2];
	assign wr_en  = psel && penable && pwrite;
	assign pready = 1'b1;
	assign cfg    = cfg_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cfg_q.sense_threshold <= RST_SENSE_THRESHOLD;
			cfg_q.gain_p          <= RST_GAIN_P;
			cfg_q.gain_d          <= RST_GAIN_D;
			cfg_q.gain_i          <= RST_GAIN_I;
			cfg_q.cruise_speed    <= RST_CRUISE_SPEED;
			cfg_q.speed_limit     <= RST_SPEED_LIMIT;
			cfg_q.spin_speed      <= RST_SPIN_SPEED;
		end else if (wr_en) begin
			unique case (idx)
				REG_SENSE_THRESHOLD: cfg_q.sense_threshold <= pwdata[THRESH_W-1:0];
				REG_GAIN_P:          cfg_q.gain_p          <= pwdata[GAIN_W-1:0];
				REG_GAIN_D:          cfg_q.gain_d          <= pwdata[GAIN_W-1:0];
				REG_GAIN_I:          cfg_q.gain_i          <= pwdata[GAIN_W-1:0];
				REG_CRUISE_SPEED:    cfg_q.cruise_speed    <= pwdata[SPEED_W-1:0];
				REG_SPEED_LIMIT:     cfg_q.speed_limit     <= pwdata[SPEED_W-1:0];
				REG_SPIN_SPEED:      cfg_q.spin_speed      <= pwdata[SPEED_W-1:0];
				default: ;
			endcase
		end
	end

	always_comb begin
		unique case (idx)
			REG_SENSE_THRESHOLD: prdata = APB_DATA_W'(cfg_q.sense_threshold);
			REG_GAIN_P:          prdata = APB_DATA_W'(cfg_q.gain_p);
			REG_GAIN_D:          prdata = APB_DATA_W'(cfg_q.gain_d);
			REG_GAIN_I:          prdata = APB_DATA_W'(cfg_q.gain_i);
			REG_CRUISE_SPEED:    prdata = APB_DATA_W'(cfg_q.cruise_speed);
			REG_SPEED_LIMIT:     prdata = APB_DATA_W'(cfg_q.speed_limit);
			REG_SPIN_SPEED:      prdata = APB_DATA_W'(cfg_q.spin_speed);
			default:             prdata = '0;
		endcase
	end

endmodule

// ===== rtl/plfd_ctrl.sv =====
module plfd_ctrl import plfd_pkg::*; #(
	parameter int FRAC_BITS = FRAC_BITS_DEF
) (
	input  logic       clk,
	input  logic       arst_n,
	input  logic       sample_valid,
	output logic       sample_stall,
	output logic       drive_valid,
	input  logic       drive_stall,
	input  plfd_stat_t stat,
	output plfd_cmd_t  cmd
);

	localparam int NUM_W      = WSUM_W + FRAC_BITS;
	localparam int DIV_CYCLES = (NUM_W + DIV_STEPS - 1) / DIV_STEPS;
	localparam int CNT_W      = (DIV_CYCLES > 1) ? $clog2(DIV_CYCLES) : 1;
	localparam logic [CNT_W-1:0] CNT_LAST = CNT_W'(DIV_CYCLES - 1);

	plfd_state_t      state_q, state_n;
	logic [CNT_W-1:0] div_cnt_q;
	logic             drive_valid_q;

	assign drive_valid = drive_valid_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q       <= ST_IDLE;
			div_cnt_q     <= '0;
			drive_valid_q <= 1'b0;
		end else begin
			state_q <= state_n;
			if (cmd.div_init) begin
				div_cnt_q <= '0;
			end else if (cmd.div_step) begin
				div_cnt_q <= div_cnt_q + CNT_W'(1);
			end
			if (cmd.commit) begin
				drive_valid_q <= 1'b1;
			end else if (drive_valid_q && !drive_stall) begin
				drive_valid_q <= 1'b0;
			end
		end
	end

	always_comb begin
		state_n      = state_q;
		cmd          = '0;
		sample_stall = 1'b1;
		unique case (state_q)
			ST_IDLE: begin
				sample_stall = 1'b0;
				if (sample_valid) begin
					cmd.load = 1'b1;
					state_n  = ST_EVAL;
				end
			end
			ST_EVAL: begin
				if (stat.pid_path) begin
					cmd.div_init = 1'b1;
					state_n      = ST_DIV;
				end else begin
					state_n = ST_EMIT;
				end
			end
			ST_DIV: begin
				cmd.div_step = 1'b1;
				if (div_cnt_q == CNT_LAST) begin
					state_n = ST_ERR;
				end
			end
			ST_ERR: begin
				cmd.err_load = 1'b1;
				state_n      = ST_MUL_P;
			end
			ST_MUL_P: begin
				cmd.mul_p = 1'b1;
				state_n   = ST_MUL_D;
			end
			ST_MUL_D: begin
				cmd.mul_d  = 1'b1;
				cmd.acc_en = 1'b1;
				state_n    = ST_MUL_I;
			end
			ST_MUL_I: begin
				cmd.mul_i  = 1'b1;
				cmd.acc_en = 1'b1;
				state_n    = ST_ACC;
			end
			ST_ACC: begin
				cmd.acc_en = 1'b1;
				state_n    = ST_SCALE;
			end
			ST_SCALE: begin
				cmd.scale = 1'b1;
				state_n   = ST_EMIT;
			end
			ST_EMIT: begin
				if (!drive_valid_q || !drive_stall) begin
					cmd.commit = 1'b1;
					state_n    = ST_IDLE;
				end
			end
			default: begin
				state_n = ST_IDLE;
			end
		endcase
	end

endmodule

// ===== rtl/plfd_datapath.sv =====
module plfd_datapath import plfd_pkg::*; #(
	parameter int FRAC_BITS = FRAC_BITS_DEF
) (
	input  logic         clk,
	input  logic         arst_n,
	input  plfd_cfg_t    cfg,
	input  plfd_sample_t sample,
	input  plfd_cmd_t    cmd,
	output plfd_stat_t   stat,
	output plfd_drive_t  drive
);

	localparam int NUM_W      = WSUM_W + FRAC_BITS;
	localparam int DIV_CYCLES = (NUM_W + DIV_STEPS - 1) / DIV_STEPS;
	localparam int DIV_W      = DIV_CYCLES * DIV_STEPS;
	localparam int REM_W      = COUNT_W + 1;
	localparam int POS_W      = FRAC_BITS + 3;
	localparam int ERR_W      = FRAC_BITS + 3;
	localparam int DIFF_W     = FRAC_BITS + 4;
	localparam int PROD_W     = GAIN_W + 1 + SUM_W;
	localparam int PID_W      = ACC_W - FRAC_BITS;

	localparam logic [POS_W-1:0] HALF7 = POS_W'(7 << (FRAC_BITS - 1));
	localparam logic signed [ACC_W-1:0] RND = ACC_W'((1 << FRAC_BITS) - 1);
	localparam logic [COUNT_W-1:0] ALL_ON = COUNT_W'(NUM_SENSORS);

	function automatic logic [SPEED_W-1:0] clamp_speed(input logic signed [PID_W:0] v,
			input logic [SPEED_W-1:0] lim);
		logic signed [PID_W:0] lim_s;
		lim_s = (PID_W+1)'({1'b0, lim});
		if (v[PID_W]) begin
			return '0;
		end else if (v > lim_s) begin
			return lim;
		end
		return v[SPEED_W-1:0];
	endfunction

	function automatic plfd_drive_t spin_word(input plfd_mode_t mode,
			input logic [SPEED_W-1:0] speed, input logic lost);
		plfd_drive_t w;
		w                = '0;
		w.left_drive     = speed;
		w.right_drive    = speed;
		w.right_backward = (mode == MODE_RIGHT);
		w.left_backward  = (mode != MODE_RIGHT);
		w.drive_mode     = mode;
		w.line_lost      = lost;
		return w;
	endfunction

	logic [SENSOR_BITS-1:0]   rd [NUM_SENSORS];
	logic [NUM_SENSORS-1:0]   on_in;
	logic [1:0]               op_q;
	logic [NUM_SENSORS-1:0]   on_q;
	logic [COUNT_W-1:0]       count;
	logic [WSUM_W-1:0]        wsum;

	logic [DIV_W-1:0]         div_q, div_nxt;
	logic [REM_W-1:0]         rem_q, rem_nxt;
	logic [POS_W-1:0]         pos;
	logic signed [ERR_W:0]    err_wide;

	logic signed [ERR_W-1:0]  err_q;
	logic signed [ERR_W-1:0]  last_error_q;
	logic signed [DIFF_W-1:0] diff_q;
	logic signed [SUM_W-1:0]  error_sum_q;
	logic signed [SUM_W:0]    sum_wide;
	logic signed [SUM_W-1:0]  sum_sat;

	logic [GAIN_W-1:0]        mul_a;
	logic signed [GAIN_W:0]   mul_a_s;
	logic signed [SUM_W-1:0]  mul_b;
	logic signed [PROD_W-1:0] prod_q;
	logic signed [ACC_W-1:0]  acc_q;
	logic signed [ACC_W-1:0]  bias;
	logic signed [ACC_W-1:0]  acc_adj;
	logic signed [PID_W-1:0]  pid_q;

	plfd_mode_t               spin_q, spin_n, spin_from_turn;
	plfd_turn_t               turn_q, turn_n, turn_upd;
	logic                     clear_pid;
	logic signed [PID_W:0]    lsum, rsum;
	logic [SPEED_W-1:0]       cruise_c, spin_c;
	plfd_drive_t              drive_q, drive_n;

	assign rd[0] = sample.reading_0;
	assign rd[1] = sample.reading_1;
	assign rd[2] = sample.reading_2;
	assign rd[3] = sample.reading_3;
	assign rd[4] = sample.reading_4;
	assign rd[5] = sample.reading_5;

	always_comb begin
		for (int i = 0; i < NUM_SENSORS; i++) begin
			on_in[i] = CMP_W'(rd[i]) > CMP_W'(cfg.sense_threshold);
		end
	end

	always_comb begin
		count = '0;
		wsum  = '0;
		for (int i = 0; i < NUM_SENSORS; i++) begin
			if (on_q[i]) begin
				count = count + COUNT_W'(1);
				wsum  = wsum + WSUM_W'(i + 1);
			end
		end
	end

	assign stat.pid_path = (op_q == OP_FOLLOW) && (spin_q == MODE_FOLLOW);

	// Restoring divider, several quotient bits per cycle; quotient bits shift in at the bottom.
	always_comb begin
		rem_nxt = rem_q;
		div_nxt = div_q;
		for (int k = 0; k < DIV_STEPS; k++) begin
			rem_nxt = {rem_nxt[REM_W-2:0], div_nxt[DIV_W-1]};
			div_nxt = {div_nxt[DIV_W-2:0], 1'b0};
			if (rem_nxt >= REM_W'(count)) begin
				rem_nxt    = rem_nxt - REM_W'(count);
				div_nxt[0] = 1'b1;
			end
		end
	end

	assign pos      = div_q[POS_W-1:0];
	assign err_wide = $signed({1'b0, HALF7}) - $signed({1'b0, pos});

	assign sum_wide = (SUM_W+1)'(error_sum_q) + (SUM_W+1)'(err_q);
	always_comb begin
		if (sum_wide[SUM_W] != sum_wide[SUM_W-1]) begin
			sum_sat = sum_wide[SUM_W] ? {1'b1, {(SUM_W-1){1'b0}}} : {1'b0, {(SUM_W-1){1'b1}}};
		end else begin
			sum_sat = sum_wide[SUM_W-1:0];
		end
	end

	always_comb begin
		priority if (cmd.mul_p) begin
			mul_a = cfg.gain_p;
			mul_b = SUM_W'(err_q);
		end else if (cmd.mul_d) begin
			mul_a = cfg.gain_d;
			mul_b = SUM_W'(diff_q);
		end else begin
			mul_a = cfg.gain_i;
			mul_b = error_sum_q;
		end
	end
	assign mul_a_s = {1'b0, mul_a};

	assign bias    = acc_q[ACC_W-1] ? RND : '0;
	assign acc_adj = acc_q + bias;

	always_comb begin
		turn_upd = turn_q;
		if (on_q[0] && !on_q[NUM_SENSORS-1]) begin
			turn_upd = TURN_RIGHT;
		end else if (!on_q[0] && on_q[NUM_SENSORS-1]) begin
			turn_upd = TURN_LEFT;
		end
		unique case (turn_upd)
			TURN_RIGHT: spin_from_turn = MODE_RIGHT;
			TURN_LEFT:  spin_from_turn = MODE_LEFT;
			default:    spin_from_turn = MODE_UTURN;
		endcase
	end

	assign cruise_c = (cfg.cruise_speed > cfg.speed_limit) ? cfg.speed_limit : cfg.cruise_speed;
	assign spin_c   = (cfg.spin_speed > cfg.speed_limit) ? cfg.speed_limit : cfg.spin_speed;
	assign lsum     = (PID_W+1)'({1'b0, cfg.cruise_speed}) + (PID_W+1)'(pid_q);
	assign rsum     = (PID_W+1)'({1'b0, cfg.cruise_speed}) - (PID_W+1)'(pid_q);

	always_comb begin
		drive_n   = '0;
		spin_n    = spin_q;
		turn_n    = turn_q;
		clear_pid = 1'b0;
		priority if (op_q != OP_FOLLOW) begin
			spin_n    = MODE_FOLLOW;
			clear_pid = (op_q == OP_CLEAR);
		end else if (spin_q != MODE_FOLLOW) begin
			if (on_q[2] || on_q[3]) begin
				spin_n = MODE_FOLLOW;
				if (count == ALL_ON) begin
					drive_n.all_seen = 1'b1;
				end else begin
					drive_n.left_drive  = cruise_c;
					drive_n.right_drive = cruise_c;
				end
			end else begin
				drive_n = spin_word(spin_q, spin_c, count == '0);
			end
		end else begin
			turn_n = turn_upd;
			priority if (count == '0) begin
				spin_n  = spin_from_turn;
				drive_n = spin_word(spin_from_turn, spin_c, 1'b1);
			end else if (count == ALL_ON) begin
				drive_n.all_seen = 1'b1;
			end else begin
				drive_n.left_drive  = clamp_speed(lsum, cfg.speed_limit);
				drive_n.right_drive = clamp_speed(rsum, cfg.speed_limit);
			end
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			error_sum_q  <= '0;
			last_error_q <= '0;
			spin_q       <= MODE_FOLLOW;
			turn_q       <= TURN_NONE;
		end else begin
			if (cmd.mul_p) begin
				error_sum_q <= sum_sat;
			end else if (cmd.commit && clear_pid) begin
				error_sum_q <= '0;
			end
			if (cmd.mul_d) begin
				last_error_q <= err_q;
			end else if (cmd.commit && clear_pid) begin
				last_error_q <= '0;
			end
			if (cmd.commit) begin
				spin_q <= spin_n;
				turn_q <= turn_n;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (cmd.load) begin
			op_q <= sample.op;
			on_q <= on_in;
		end
		if (cmd.div_init) begin
			div_q <= DIV_W'(wsum) << FRAC_BITS;
			rem_q <= '0;
		end else if (cmd.div_step) begin
			div_q <= div_nxt;
			rem_q <= rem_nxt;
		end
		if (cmd.err_load) begin
			err_q <= (count == '0) ? '0 : err_wide[ERR_W-1:0];
			acc_q <= '0;
		end else if (cmd.acc_en) begin
			acc_q <= acc_q + ACC_W'(prod_q);
		end
		if (cmd.mul_p) begin
			diff_q <= DIFF_W'(err_q) - DIFF_W'(last_error_q);
		end
		if (cmd.mul_p || cmd.mul_d || cmd.mul_i) begin
			prod_q <= mul_a_s * mul_b;
		end
		if (cmd.scale) begin
			pid_q <= acc_adj[ACC_W-1:FRAC_BITS];
		end
		if (cmd.commit) begin
			drive_q <= drive_n;
		end
	end

	assign drive = drive_q;

endmodule

// ===== rtl/pid_line_follower_drive.sv =====
// Six-sensor line follower with PID steering.
// Samples arrive as words on the sample channel (valid/stall); one drive word per
// sample leaves on the drive channel (valid/stall). A sample is taken when
// sample_valid is high and sample_stall is low; likewise for drive words.
// A follow sample passes through evaluate, the divider steps, error, the P, D and
// I products, accumulate, scale and emit before its drive word is registered; a
// stop, clear or spin sample goes from evaluate straight to emit. The block works
// on one sample at a time and takes the next one only once the word is registered
// and the sequencer is back in idle. The position divider (4 quotient bits a cycle)
// and the single shared gain multiplier, used once for each of the three PID terms,
// make the follow path the longer one.
// The drive word sits in an output register, so a new sample is taken while an
// earlier word still waits; a stalled receiver holds the word, and the next word
// is held back in the final step until the register frees.
// Reset clears the integral, the last error, the edge memory and the spin mode and
// loads the register defaults; no clearing pass is needed. Registers are written
// over the APB port and should only change while no sample is in flight.
`include "pid_line_follower_drive_assert.svh"

module pid_line_follower_drive import plfd_pkg::*; #(
	parameter int FRAC_BITS = FRAC_BITS_DEF
) (
	input  logic                  clk,
	input  logic                  arst_n,
	input  logic                  sample_valid,
	output logic                  sample_stall,
	input  plfd_sample_t          sample,
	output logic                  drive_valid,
	input  logic                  drive_stall,
	output plfd_drive_t           drive,
	input  logic                  psel,
	input  logic                  penable,
	input  logic                  pwrite,
	input  logic [PADDR_W-1:0]    paddr,
	input  logic [APB_DATA_W-1:0] pwdata,
	output logic [APB_DATA_W-1:0] prdata,
	output logic                  pready
);

	plfd_cfg_t  cfg;
	plfd_cmd_t  cmd;
	plfd_stat_t stat;

	// Register bank for thresholds, gains and speeds.
	plfd_regs u_regs (
		.clk     (clk),
		.arst_n  (arst_n),
		.psel    (psel),
		.penable (penable),
		.pwrite  (pwrite),
		.paddr   (paddr),
		.pwdata  (pwdata),
		.prdata  (prdata),
		.pready  (pready),
		.cfg     (cfg)
	);

	// The sequencer steps through divide, error, the three products, scaling and
	// the final commit of the drive word.
	plfd_ctrl #(
		.FRAC_BITS (FRAC_BITS)
	) u_ctrl (
		.clk          (clk),
		.arst_n       (arst_n),
		.sample_valid (sample_valid),
		.sample_stall (sample_stall),
		.drive_valid  (drive_valid),
		.drive_stall  (drive_stall),
		.stat         (stat),
		.cmd          (cmd)
	);

	// The datapath holds the sample, the divider, the shared multiplier, the PID
	// state, the edge memory, the spin mode and the output register.
	plfd_datapath #(
		.FRAC_BITS (FRAC_BITS)
	) u_dp (
		.clk    (clk),
		.arst_n (arst_n),
		.cfg    (cfg),
		.sample (sample),
		.cmd    (cmd),
		.stat   (stat),
		.drive  (drive)
	);

	// Once a sample is taken, the block is busy in the next cycle.
	`PLFD_ASSERT_NEXT(a_busy_after_take, clk, arst_n, sample_valid && !sample_stall, sample_stall)
	// A new drive word only shows up after the sequencer committed one.
	`PLFD_ASSERT_SAME(a_word_from_commit, clk, arst_n, $rose(drive_valid), $past(cmd.commit))
	// All sensors on means both motors stop and the line is not lost.
	`PLFD_ASSERT_SAME(a_all_seen_stops, clk, arst_n, drive_valid && drive.all_seen, drive.left_drive == 8'd0 && drive.right_drive == 8'd0 && !drive.line_lost)
	// A lost line is always answered by a spin or a U-turn.
	`PLFD_ASSERT_SAME(a_lost_spins, clk, arst_n, drive_valid && drive.line_lost, drive.drive_mode != MODE_FOLLOW)

endmodule

// ===== tb/sv/testbench.sv =====
module testbench;
	import plfd_pkg::*;

	// The op field is two bits wide but the package only names three codes. The fourth
	// code must behave exactly like a stop, so it gets a name of its own here.
	localparam logic [1:0] OP_RESERVED = 2'd3;

	localparam int FRAC = FRAC_BITS_DEF;
	localparam longint SUM_HI = (longint'(1) << (SUM_W - 1)) - 1;
	localparam longint SUM_LO = -(longint'(1) << (SUM_W - 1));

	// Reading levels for the directed part. With the reset threshold of 512, a reading
	// of exactly 512 is still off and 513 is the lowest reading that counts as on.
	localparam int HI = 1023;
	localparam int LO = 0;
	localparam int AT = 512;
	localparam int ABOVE = 513;

	logic clk = 1'b0;
	logic arst_n = 1'b0;
	logic sample_valid = 1'b0;
	logic sample_stall;
	plfd_sample_t sample = '0;
	logic drive_valid;
	logic drive_stall = 1'b0;
	plfd_drive_t drive;
	logic psel = 1'b0;
	logic penable = 1'b0;
	logic pwrite = 1'b0;
	logic [PADDR_W-1:0] paddr = '0;
	logic [APB_DATA_W-1:0] pwdata = '0;
	logic [APB_DATA_W-1:0] prdata;
	logic pready;

	// When steady is set, neither the sample sender nor the drive receiver idles, so
	// the block runs back to back for a while.
	bit steady = 1'b0;
	int bad_words = 0;

	// Drive words predicted for accepted samples, oldest first.
	plfd_drive_t pending_drive[$];

	// Our own copy of the register file and of the steering state.
	plfd_cfg_t cfg_model = '{
		sense_threshold: RST_SENSE_THRESHOLD,
		gain_p: RST_GAIN_P,
		gain_d: RST_GAIN_D,
		gain_i: RST_GAIN_I,
		cruise_speed: RST_CRUISE_SPEED,
		speed_limit: RST_SPEED_LIMIT,
		spin_speed: RST_SPIN_SPEED
	};
	logic signed [SUM_W-1:0] integ = '0;
	int last_err = 0;
	plfd_turn_t turn_mem = TURN_NONE;
	plfd_mode_t spin_st = MODE_FOLLOW;

	pid_line_follower_drive dut (
		.clk(clk),
		.arst_n(arst_n),
		.sample_valid(sample_valid),
		.sample_stall(sample_stall),
		.sample(sample),
		.drive_valid(drive_valid),
		.drive_stall(drive_stall),
		.drive(drive),
		.psel(psel),
		.penable(penable),
		.pwrite(pwrite),
		.paddr(paddr),
		.pwdata(pwdata),
		.prdata(prdata),
		.pready(pready)
	);

	always #2 clk = ~clk;

	// The receiver holds off drive words at random, except during steady stretches.
	always @(posedge clk) begin
		drive_stall <= !steady && ($urandom_range(99) < 13);
	end

	function automatic logic [SPEED_W-1:0] clamp_speed(input longint v);
		longint cap;
		cap = longint'(cfg_model.speed_limit);
		if (v < 0)
			return '0;
		if (v > cap)
			return cfg_model.speed_limit;
		return v[SPEED_W-1:0];
	endfunction

	// While spinning, both motors run at the spin speed, capped at the speed limit. A right
	// spin reverses the right motor; a left spin and a U-turn reverse the left one.
	function automatic plfd_drive_t spin_word(input plfd_mode_t m, input logic lost);
		plfd_drive_t d;
		d = '0;
		d.left_drive = clamp_speed(longint'(cfg_model.spin_speed));
		d.right_drive = d.left_drive;
		d.right_backward = (m == MODE_RIGHT);
		d.left_backward = (m != MODE_RIGHT);
		d.drive_mode = m;
		d.line_lost = lost;
		return d;
	endfunction

	// Works out the drive word for one accepted sample and advances the steering state.
	function automatic plfd_drive_t predict_drive(input plfd_sample_t s);
		plfd_drive_t d;
		logic [SENSOR_BITS-1:0] rd [NUM_SENSORS];
		bit on [NUM_SENSORS];
		int cnt;
		int wsum;
		int err;
		longint total;
		longint acc;
		longint pid;
		d = '0;

		// Every op other than a follow sample stops the motors and cancels a spin.
		// Only the clear op also forgets the integral and the last error.
		if (s.op != OP_FOLLOW) begin
			if (s.op == OP_CLEAR) begin
				integ = '0;
				last_err = 0;
			end
			spin_st = MODE_FOLLOW;
			return d;
		end

		rd[0] = s.reading_0;
		rd[1] = s.reading_1;
		rd[2] = s.reading_2;
		rd[3] = s.reading_3;
		rd[4] = s.reading_4;
		rd[5] = s.reading_5;
		cnt = 0;
		wsum = 0;
		for (int i = 0; i < NUM_SENSORS; i++) begin
			on[i] = rd[i] > cfg_model.sense_threshold;
			if (on[i]) begin
				cnt++;
				wsum += i + 1;
			end
		end

		// A spin runs without any PID step until one of the two middle sensors finds the
		// line again; then the robot goes straight at cruise speed, or stops if all are on.
		if (spin_st != MODE_FOLLOW) begin
			if (on[2] || on[3]) begin
				spin_st = MODE_FOLLOW;
				if (cnt == NUM_SENSORS) begin
					d.all_seen = 1'b1;
				end else begin
					d.left_drive = clamp_speed(longint'(cfg_model.cruise_speed));
					d.right_drive = d.left_drive;
				end
			end else begin
				d = spin_word(spin_st, cnt == 0);
			end
			return d;
		end

		// The error is 3.5 minus the weighted line position, both in fixed point, and
		// zero when no sensor is on. The PID step runs even when the line is lost.
		err = 0;
		if (cnt > 0)
			err = (7 << (FRAC - 1)) - ((wsum << FRAC) / cnt);
		total = longint'(integ) + err;
		if (total > SUM_HI)
			total = SUM_HI;
		if (total < SUM_LO)
			total = SUM_LO;
		integ = total[SUM_W-1:0];
		acc = longint'(cfg_model.gain_p) * err
			+ longint'(cfg_model.gain_d) * (err - last_err)
			+ longint'(cfg_model.gain_i) * total;
		last_err = err;
		// Signed division truncates toward zero, as the scaling requires.
		pid = acc / (longint'(1) << FRAC);

		// Only an edge sensor seen alone updates the turn memory; both edges or neither
		// leave it as it was.
		if (on[0] && !on[5])
			turn_mem = TURN_RIGHT;
		if (!on[0] && on[5])
			turn_mem = TURN_LEFT;

		if (cnt == 0) begin
			spin_st = (turn_mem == TURN_RIGHT) ? MODE_RIGHT
				: (turn_mem == TURN_LEFT) ? MODE_LEFT : MODE_UTURN;
			d = spin_word(spin_st, 1'b1);
		end else if (cnt == NUM_SENSORS) begin
			d.all_seen = 1'b1;
		end else begin
			d.left_drive = clamp_speed(longint'(cfg_model.cruise_speed) + pid);
			d.right_drive = clamp_speed(longint'(cfg_model.cruise_speed) - pid);
		end
		return d;
	endfunction

	// Every decision about a handshake is taken at the falling edge, where all signals
	// are settled, and takes effect at the next rising edge. A drive word is accepted
	// at the rising edge that follows a falling edge with valid high and stall low.
	always @(negedge clk) begin
		plfd_drive_t want;
		if (arst_n && drive_valid && !drive_stall) begin
			if (pending_drive.size() == 0) begin
				bad_words++;
				if (bad_words <= 10)
					$display("unexpected drive word %h at %0t", drive, $realtime);
			end else begin
				want = pending_drive.pop_front();
				if (drive.left_drive !== want.left_drive
						|| drive.right_drive !== want.right_drive
						|| drive.left_backward !== want.left_backward
						|| drive.right_backward !== want.right_backward
						|| drive.drive_mode !== want.drive_mode
						|| drive.all_seen !== want.all_seen
						|| drive.line_lost !== want.line_lost) begin
					bad_words++;
					if (bad_words <= 10) begin
						$display("drive mismatch at %0t: expected l=%0d r=%0d lb=%b rb=%b mode=%0d all=%b lost=%b",
							$realtime, want.left_drive, want.right_drive,
							want.left_backward, want.right_backward, want.drive_mode,
							want.all_seen, want.line_lost);
						$display("  got l=%0d r=%0d lb=%b rb=%b mode=%0d all=%b lost=%b",
							drive.left_drive, drive.right_drive, drive.left_backward,
							drive.right_backward, drive.drive_mode, drive.all_seen,
							drive.line_lost);
					end
				end
			end
		end
	end

	// Sends one sample word. The task returns at the falling edge just before the
	// edge that accepts the word, so the next call (or the drain) lowers or reloads
	// valid at that very edge and valid never drops between back-to-back words.
	task automatic send_word(input logic [1:0] op, input int r0, input int r1,
			input int r2, input int r3, input int r4, input int r5);
		plfd_sample_t s;
		s.op = op;
		s.reading_0 = r0[SENSOR_BITS-1:0];
		s.reading_1 = r1[SENSOR_BITS-1:0];
		s.reading_2 = r2[SENSOR_BITS-1:0];
		s.reading_3 = r3[SENSOR_BITS-1:0];
		s.reading_4 = r4[SENSOR_BITS-1:0];
		s.reading_5 = r5[SENSOR_BITS-1:0];
		while (!steady && $urandom_range(99) < 13) begin
			@(posedge clk);
			sample_valid <= 1'b0;
		end
		@(posedge clk);
		sample_valid <= 1'b1;
		sample <= s;
		do @(negedge clk); while (sample_stall);
		pending_drive.push_back(predict_drive(s));
	endtask

	// Lets the last word go, then waits until every drive word has come back. Every
	// sample yields exactly one drive word, so an empty store means the block is idle;
	// the short pause only keeps register writes clear of the final handshake.
	task automatic wait_drained();
		@(posedge clk);
		sample_valid <= 1'b0;
		while (pending_drive.size() != 0)
			@(negedge clk);
		repeat (4) @(posedge clk);
	endtask

	// One APB write followed by a read of the same register. The write lands at the
	// edge that ends its access cycle, which is also where the read's setup begins.
	task automatic write_reg(input logic [REG_IDX_W-1:0] idx, input logic [31:0] val);
		logic [31:0] want;
		case (idx)
			REG_SENSE_THRESHOLD: begin
				cfg_model.sense_threshold = val[THRESH_W-1:0];
				want = 32'(val[THRESH_W-1:0]);
			end
			REG_GAIN_P: begin
				cfg_model.gain_p = val[GAIN_W-1:0];
				want = 32'(val[GAIN_W-1:0]);
			end
			REG_GAIN_D: begin
				cfg_model.gain_d = val[GAIN_W-1:0];
				want = 32'(val[GAIN_W-1:0]);
			end
			REG_GAIN_I: begin
				cfg_model.gain_i = val[GAIN_W-1:0];
				want = 32'(val[GAIN_W-1:0]);
			end
			REG_CRUISE_SPEED: begin
				cfg_model.cruise_speed = val[SPEED_W-1:0];
				want = 32'(val[SPEED_W-1:0]);
			end
			REG_SPEED_LIMIT: begin
				cfg_model.speed_limit = val[SPEED_W-1:0];
				want = 32'(val[SPEED_W-1:0]);
			end
			default: begin
				cfg_model.spin_speed = val[SPEED_W-1:0];
				want = 32'(val[SPEED_W-1:0]);
			end
		endcase
		@(posedge clk);
		psel <= 1'b1;
		penable <= 1'b0;
		pwrite <= 1'b1;
		paddr <= {idx, 2'b00};
		pwdata <= val;
		@(posedge clk);
		penable <= 1'b1;
		do @(negedge clk); while (!pready);
		@(posedge clk);
		penable <= 1'b0;
		pwrite <= 1'b0;
		@(posedge clk);
		penable <= 1'b1;
		do @(negedge clk); while (!pready);
		if (prdata !== want) begin
			bad_words++;
			if (bad_words <= 10)
				$display("register %0d reads %h, expected %h", idx, prdata, want);
		end
		@(posedge clk);
		psel <= 1'b0;
		penable <= 1'b0;
	endtask

	task automatic set_config(input logic [31:0] thr, input logic [31:0] gp,
			input logic [31:0] gd, input logic [31:0] gi, input logic [31:0] cruise,
			input logic [31:0] lim, input logic [31:0] spin);
		wait_drained();
		write_reg(REG_SENSE_THRESHOLD, thr);
		write_reg(REG_GAIN_P, gp);
		write_reg(REG_GAIN_D, gd);
		write_reg(REG_GAIN_I, gi);
		write_reg(REG_CRUISE_SPEED, cruise);
		write_reg(REG_SPEED_LIMIT, lim);
		write_reg(REG_SPIN_SPEED, spin);
	endtask

	// Readings that count as on or off under the current threshold. At the top
	// threshold nothing can be on, so the "on" level is then simply the maximum.
	function automatic int level_on();
		int thr;
		thr = cfg_model.sense_threshold;
		if (thr >= HI)
			return HI;
		return $urandom_range(HI, thr + 1);
	endfunction

	function automatic int level_off();
		return $urandom_range(int'(cfg_model.sense_threshold), LO);
	endfunction

	// Random samples shaped like a real track: mostly a line under one to three
	// adjacent sensors, with lost lines that start spins, full crossings, stops, and
	// some fully random noise that makes every reading bit toggle.
	task automatic run_random(input int n);
		int lv [NUM_SENSORS];
		logic [1:0] op;
		int pick;
		int c;
		int w;
		for (int k = 0; k < n; k++) begin
			op = OP_FOLLOW;
			for (int i = 0; i < NUM_SENSORS; i++)
				lv[i] = level_off();
			pick = $urandom_range(99);
			if (pick < 7) begin
				case ($urandom_range(2))
					0: op = OP_CLEAR;
					1: op = OP_STOP;
					default: op = OP_RESERVED;
				endcase
				for (int i = 0; i < NUM_SENSORS; i++)
					lv[i] = $urandom_range(HI, LO);
			end else if (pick < 15) begin
				for (int i = 0; i < NUM_SENSORS; i++)
					lv[i] = $urandom_range(HI, LO);
			end else if (pick < 24) begin
				// Line lost: every reading stays at or below the threshold.
			end else if (pick < 27) begin
				for (int i = 0; i < NUM_SENSORS; i++)
					lv[i] = level_on();
			end else begin
				c = $urandom_range(NUM_SENSORS - 1);
				w = $urandom_range(3, 1);
				for (int i = c; i < c + w && i < NUM_SENSORS; i++)
					lv[i] = level_on();
				if ($urandom_range(9) == 0)
					lv[$urandom_range(NUM_SENSORS - 1)] = level_on();
			end
			send_word(op, lv[0], lv[1], lv[2], lv[3], lv[4], lv[5]);
		end
	endtask

	// Hand-picked samples at the reset settings. The order matters: the very first
	// lost line has no edge in memory and must start a U-turn, and each later lost
	// line checks that the edge seen last picks the spin direction.
	task automatic test_directed_cases();
		send_word(OP_FOLLOW, LO, LO, LO, LO, LO, LO);
		send_word(OP_FOLLOW, LO, HI, LO, LO, LO, LO);
		send_word(OP_FOLLOW, HI, HI, HI, HI, HI, HI);
		send_word(OP_FOLLOW, HI, LO, LO, LO, LO, LO);
		send_word(OP_FOLLOW, LO, LO, LO, LO, LO, LO);
		// An edge sensor seen during a spin must not change the turn memory.
		send_word(OP_FOLLOW, LO, LO, LO, LO, LO, HI);
		send_word(OP_FOLLOW, LO, LO, HI, LO, LO, LO);
		send_word(OP_FOLLOW, LO, LO, LO, LO, LO, HI);
		send_word(OP_FOLLOW, LO, LO, LO, LO, LO, LO);
		send_word(OP_STOP, HI, HI, HI, HI, HI, HI);
		// Readings exactly at the threshold are off, so this is a lost line.
		send_word(OP_FOLLOW, AT, AT, AT, AT, AT, AT);
		send_word(OP_CLEAR, HI, HI, HI, HI, HI, HI);
		send_word(OP_FOLLOW, LO, LO, ABOVE, ABOVE, LO, LO);
		send_word(OP_FOLLOW, LO, HI, LO, LO, LO, LO);
		send_word(OP_FOLLOW, LO, LO, LO, LO, HI, LO);
		send_word(OP_FOLLOW, LO, LO, LO, HI, LO, LO);
		send_word(OP_FOLLOW, HI, HI, HI, HI, HI, LO);
		send_word(OP_FOLLOW, LO, HI, HI, HI, HI, HI);
		// Both edges at once keep whatever the memory held.
		send_word(OP_FOLLOW, HI, LO, LO, LO, LO, HI);
		send_word(OP_FOLLOW, LO, LO, LO, LO, LO, LO);
		send_word(OP_RESERVED, HI, LO, HI, LO, HI, LO);
		send_word(OP_FOLLOW, HI, HI, HI, HI, HI, HI);
		send_word(OP_FOLLOW, HI, LO, HI, LO, HI, LO);
		send_word(OP_STOP, LO, LO, LO, LO, LO, LO);
	endtask

	// Random track at the reset settings, first back to back, then with idling.
	task automatic test_random_defaults();
		steady = 1'b1;
		run_random(80);
		steady = 1'b0;
		run_random(160);
	endtask

	// The register extremes: a threshold nothing can pass, a threshold everything
	// nonzero passes with the largest gains, and everything at zero.
	task automatic test_config_extremes();
		set_config(HI, 32'hFFF, 32'hFFF, 32'hFFF, 32'hFF, 32'hFF, 32'hFF);
		run_random(50);
		set_config(LO, 32'hFFF, 32'hFFF, 32'hFFF, 32'hFF, 32'hFF, 32'hFF);
		run_random(80);
		set_config(LO, 0, 0, 0, 0, 0, 0);
		run_random(80);
	endtask

	// Random settings, with random upper bits on the bus to check that each
	// register keeps only its own width.
	task automatic test_random_settings();
		for (int p = 0; p < 4; p++) begin
			set_config($urandom(), $urandom(), $urandom(), $urandom(), $urandom(),
				$urandom(), $urandom());
			run_random(150);
		end
	endtask

	task automatic finish_run();
		int waited = 0;
		@(posedge clk);
		sample_valid <= 1'b0;
		while (pending_drive.size() != 0 && waited < 4000) begin
			@(negedge clk);
			waited++;
		end
		repeat (30) @(posedge clk);
		if (bad_words == 0 && pending_drive.size() == 0) begin
			$display("testbench: done, clean");
		end else begin
			$display("testbench: done, errors");
		end
		$finish;
	endtask

	initial begin
		repeat (10) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);
		test_directed_cases();
		test_random_defaults();
		test_config_extremes();
		test_random_settings();
		finish_run();
	end

	// A run that hangs is stopped here and reported as errors.
	initial begin
		#2000000;
		$display("testbench: done, errors");
		$finish;
	end

endmodule
